// File: design/xpr_pkg.sv
// Shared types, codes and the CRC byte update for the XMODEM packet receiver.
// Depends on nothing; every design file refers to it by scoped names.
package xpr_pkg;

  // Control bytes seen in idle
  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_C   = 8'h43;

  localparam logic [15:0] CRC_POLY        = 16'h1021;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd300;
  localparam logic [7:0]  BLOCK_SUM       = 8'hFF;
  localparam int          QUEUE_DEPTH     = 2;

  // Configuration register indexes
  localparam logic [1:0] REG_CHECK_MODE = 2'd0;
  localparam logic [1:0] REG_TIMEOUT    = 2'd1;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_SOH,
    CLS_EOT,
    CLS_CAN,
    CLS_C
  } byte_class_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_DATA,
    PH_CHECK
  } phase_t;

  typedef enum logic [2:0] {
    EV_DATA,
    EV_GOOD,
    EV_BAD_BLOCK,
    EV_BAD_CHECK,
    EV_TIMEOUT,
    EV_END,
    EV_CANCEL,
    EV_PEER_C
  } event_t;

  typedef enum logic [1:0] {
    RP_NONE,
    RP_ACK,
    RP_NAK
  } reply_t;

  // One classified transaction as it sits in the queue
  typedef struct packed {
    logic        is_tick;
    byte_class_t cls;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic        check_mode;
    logic [15:0] tick_limit;
  } cfg_t;

  typedef struct packed {
    event_t      ev;
    reply_t      reply;
    logic [7:0]  packet_number;
    logic [7:0]  data_byte;
    logic [6:0]  byte_index;
    logic [15:0] received_check;
    logic [15:0] computed_check;
  } result_t;

  // CRC-16/XMODEM over one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: design/xpr_front.sv
// Front end: classifies each incoming transaction (tick or byte kind).
// Depends on xpr_pkg.
module xpr_front (
  input  logic            func,
  input  logic [7:0]      rx_byte,
  output xpr_pkg::item_t  item
);

  // Decode the control bytes once, ahead of the queue
  always_comb begin
    item.is_tick = func;
    item.data    = rx_byte;
    unique case (rx_byte)
      xpr_pkg::B_SOH: item.cls = xpr_pkg::CLS_SOH;
      xpr_pkg::B_EOT: item.cls = xpr_pkg::CLS_EOT;
      xpr_pkg::B_CAN: item.cls = xpr_pkg::CLS_CAN;
      xpr_pkg::B_C:   item.cls = xpr_pkg::CLS_C;
      default:        item.cls = xpr_pkg::CLS_OTHER;
    endcase
  end

endmodule

// File: design/xpr_queue.sv
// Two-entry queue of classified transactions between front and back.
// Depends on xpr_pkg.
module xpr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  xpr_pkg::item_t  push_item,
  input  logic            pop,
  output xpr_pkg::item_t  head,
  output logic            empty,
  output logic            full
);

  localparam int PW = $clog2(xpr_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(xpr_pkg::QUEUE_DEPTH + 1);

  xpr_pkg::item_t        slots [xpr_pkg::QUEUE_DEPTH];
  logic [PW-1:0]         wr_ptr;
  logic [PW-1:0]         rd_ptr;
  logic [CW-1:0]         count;

  assign empty = (count == CW'(0));
  assign full  = (count == CW'(xpr_pkg::QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(xpr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(xpr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// File: design/xpr_back.sv
// Back end: packet state machine, check accumulators, receive timer and
// the output register. Depends on xpr_pkg.
module xpr_back #(
  parameter int PAYLOAD_BYTES = 128,
  parameter int TIMER_WIDTH   = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  xpr_pkg::cfg_t     cfg,
  input  xpr_pkg::item_t    item,
  input  logic              item_valid,
  output logic              item_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output xpr_pkg::result_t  res
);

  localparam int CW   = $clog2(PAYLOAD_BYTES);
  localparam int CMPW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
  localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

  xpr_pkg::phase_t         phase, phase_next;
  logic [7:0]              block_number, block_number_next;
  logic [CW-1:0]           byte_counter, byte_counter_next;
  logic [15:0]             crc_accum, crc_accum_next;
  logic [7:0]              sum_accum, sum_accum_next;
  logic [7:0]              check_high, check_high_next;
  logic                    high_seen, high_seen_next;
  logic [TIMER_WIDTH-1:0]  timer_count, timer_count_next;
  logic                    timer_running, timer_running_next;

  xpr_pkg::result_t        res_new;
  logic                    has_res;
  logic [TIMER_WIDTH-1:0]  timer_inc;
  logic [8:0]              hdr_sum;
  logic [15:0]             crc_rx;

  // Take a transaction whenever the output slot is free or being emptied
  assign item_pop = item_valid && (!out_valid || !out_stall);

  assign timer_inc = (timer_count < TMAX) ? timer_count + TIMER_WIDTH'(1) : timer_count;
  assign hdr_sum   = {1'b0, block_number} + {1'b0, item.data};
  assign crc_rx    = {check_high, item.data};

  // Next state and result for the transaction at the queue head
  always_comb begin
    phase_next         = phase;
    block_number_next  = block_number;
    byte_counter_next  = byte_counter;
    crc_accum_next     = crc_accum;
    sum_accum_next     = sum_accum;
    check_high_next    = check_high;
    high_seen_next     = high_seen;
    timer_count_next   = timer_count;
    timer_running_next = timer_running;
    res_new            = '0;
    has_res            = 1'b0;

    if (item.is_tick) begin
      if (timer_running) begin
        timer_count_next = timer_inc;
        if (CMPW'(timer_inc) >= CMPW'(cfg.tick_limit)) begin
          has_res               = 1'b1;
          res_new.ev            = xpr_pkg::EV_TIMEOUT;
          res_new.reply         = xpr_pkg::RP_NAK;
          res_new.packet_number = block_number;
          phase_next            = xpr_pkg::PH_IDLE;
          timer_running_next    = 1'b0;
          timer_count_next      = '0;
          high_seen_next        = 1'b0;
        end
      end
    end else begin
      unique case (phase)
        xpr_pkg::PH_IDLE: begin
          unique case (item.cls)
            xpr_pkg::CLS_C: begin
              has_res    = 1'b1;
              res_new.ev = xpr_pkg::EV_PEER_C;
            end
            xpr_pkg::CLS_EOT: begin
              has_res       = 1'b1;
              res_new.ev    = xpr_pkg::EV_END;
              res_new.reply = xpr_pkg::RP_ACK;
            end
            xpr_pkg::CLS_CAN: begin
              has_res    = 1'b1;
              res_new.ev = xpr_pkg::EV_CANCEL;
            end
            xpr_pkg::CLS_SOH: begin
              phase_next         = xpr_pkg::PH_HEADER;
              block_number_next  = '0;
              byte_counter_next  = '0;
              crc_accum_next     = '0;
              sum_accum_next     = '0;
              check_high_next    = '0;
              high_seen_next     = 1'b0;
              timer_count_next   = '0;
              timer_running_next = 1'b1;
            end
            default: begin
            end
          endcase
        end

        // Block number, then its complement
        xpr_pkg::PH_HEADER: begin
          if (!byte_counter[0]) begin
            block_number_next = item.data;
            byte_counter_next = CW'(1);
          end else if (hdr_sum == {1'b0, xpr_pkg::BLOCK_SUM}) begin
            phase_next        = xpr_pkg::PH_DATA;
            byte_counter_next = '0;
          end else begin
            has_res               = 1'b1;
            res_new.ev            = xpr_pkg::EV_BAD_BLOCK;
            res_new.reply         = xpr_pkg::RP_NAK;
            res_new.packet_number = block_number;
            phase_next            = xpr_pkg::PH_IDLE;
            timer_running_next    = 1'b0;
            timer_count_next      = '0;
            high_seen_next        = 1'b0;
          end
        end

        // Payload bytes pass straight through
        xpr_pkg::PH_DATA: begin
          sum_accum_next        = sum_accum + item.data;
          crc_accum_next        = xpr_pkg::crc_byte(crc_accum, item.data);
          has_res               = 1'b1;
          res_new.ev            = xpr_pkg::EV_DATA;
          res_new.packet_number = block_number;
          res_new.data_byte     = item.data;
          res_new.byte_index    = byte_counter[6:0];
          if (byte_counter == CW'(PAYLOAD_BYTES - 1)) begin
            phase_next        = xpr_pkg::PH_CHECK;
            byte_counter_next = '0;
            high_seen_next    = 1'b0;
          end else begin
            byte_counter_next = byte_counter + CW'(1);
          end
        end

        // One sum byte, or the CRC high then low byte
        xpr_pkg::PH_CHECK: begin
          if (!cfg.check_mode || high_seen) begin
            has_res               = 1'b1;
            res_new.packet_number = block_number;
            if (!cfg.check_mode) begin
              res_new.received_check = {8'h00, item.data};
              res_new.computed_check = {8'h00, sum_accum};
            end else begin
              res_new.received_check = crc_rx;
              res_new.computed_check = crc_accum;
            end
            if (res_new.received_check == res_new.computed_check) begin
              res_new.ev    = xpr_pkg::EV_GOOD;
              res_new.reply = xpr_pkg::RP_ACK;
            end else begin
              res_new.ev    = xpr_pkg::EV_BAD_CHECK;
              res_new.reply = xpr_pkg::RP_NAK;
            end
            phase_next         = xpr_pkg::PH_IDLE;
            timer_running_next = 1'b0;
            timer_count_next   = '0;
            high_seen_next     = 1'b0;
          end else begin
            check_high_next = item.data;
            high_seen_next  = 1'b1;
          end
        end

        default: begin
          phase_next = xpr_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= xpr_pkg::PH_IDLE;
      block_number  <= '0;
      byte_counter  <= '0;
      crc_accum     <= '0;
      sum_accum     <= '0;
      check_high    <= '0;
      high_seen     <= 1'b0;
      timer_count   <= '0;
      timer_running <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (item_pop) begin
        phase         <= phase_next;
        block_number  <= block_number_next;
        byte_counter  <= byte_counter_next;
        crc_accum     <= crc_accum_next;
        sum_accum     <= sum_accum_next;
        check_high    <= check_high_next;
        high_seen     <= high_seen_next;
        timer_count   <= timer_count_next;
        timer_running <= timer_running_next;
      end
      if (item_pop && has_res) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (item_pop && has_res) begin
      res <= res_new;
    end
  end

endmodule

// File: design/xmodem_packet_receiver.sv
// Top level of the XMODEM packet receiver: config registers, front end,
// queue and back end. Depends on xpr_pkg, xpr_front, xpr_queue, xpr_back.
//
// Usage:
//   Input channel (in_valid/in_stall): func selects a received byte (0) or
//   one timer tick (1); rx_byte carries the byte. A transaction is taken
//   when in_valid is high and in_stall is low.
//   Output channel (out_valid/out_stall): at most one result per input,
//   carrying event_res, reply and the packet fields; unused fields are 0.
//   Config channel (cfg_valid/cfg_ready): index 0 is check_mode, index 1 is
//   the receive tick limit; other indexes are ignored. cfg_ready is always high.
// Timing:
//   One transaction per cycle sustained while out_stall is low. Each input
//   is written into the two-entry queue by the accepting edge; then the
//   state machine runs on it (CRC and sum per payload byte, timer per tick)
//   and loads the output register.
//   When out_stall holds the output register full, the queue fills and
//   in_stall rises; nothing is dropped.
// Reset:
//   rst is synchronous; it empties the queue, returns to idle with the
//   timer stopped, and loads check_mode = 1 and a tick limit of 300.
module xmodem_packet_receiver #(
  parameter int PAYLOAD_BYTES = 128,
  parameter int TIMER_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [1:0]  reply,
  output logic [7:0]  packet_number,
  output logic [7:0]  data_byte,
  output logic [6:0]  byte_index,
  output logic [15:0] received_check,
  output logic [15:0] computed_check,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  xpr_pkg::cfg_t     cfg;
  xpr_pkg::item_t    front_item;
  xpr_pkg::item_t    head_item;
  xpr_pkg::result_t  res;
  logic              q_empty;
  logic              q_full;
  logic              q_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_mode <= 1'b1;
      cfg.tick_limit <= xpr_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == xpr_pkg::REG_CHECK_MODE) begin
        cfg.check_mode <= cfg_data[0];
      end else if (cfg_index == xpr_pkg::REG_TIMEOUT) begin
        cfg.tick_limit <= cfg_data;
      end
    end
  end

  xpr_front u_front (
    .func    (func),
    .rx_byte (rx_byte),
    .item    (front_item)
  );

  xpr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_item (front_item),
    .pop       (q_pop),
    .head      (head_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  xpr_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .TIMER_WIDTH   (TIMER_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (head_item),
    .item_valid (!q_empty),
    .item_pop   (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res        (res)
  );

  assign event_res      = res.ev;
  assign reply          = res.reply;
  assign packet_number  = res.packet_number;
  assign data_byte      = res.data_byte;
  assign byte_index     = res.byte_index;
  assign received_check = res.received_check;
  assign computed_check = res.computed_check;

endmodule
